/* sv/pon_pkg.sv */
// Shared types, constants and field indexes for the patch orientation normalize block.
`timescale 1ns / 1ps

package pon_pkg;

    localparam int PIX_W    = 8;
    localparam int NUM_PIX  = 9;
    localparam int RING_LEN = 8;
    localparam int BIN_W    = 3;

    // Field indexes of the patch, in transaction order.
    localparam int IDX_UP_LEFT    = 0;
    localparam int IDX_UP         = 1;
    localparam int IDX_UP_RIGHT   = 2;
    localparam int IDX_LEFT       = 3;
    localparam int IDX_CENTRE     = 4;
    localparam int IDX_RIGHT      = 5;
    localparam int IDX_DOWN_LEFT  = 6;
    localparam int IDX_DOWN       = 7;
    localparam int IDX_DOWN_RIGHT = 8;

    // tan(pi/8) as an unsigned 0.20 fraction.
    localparam int TAN_W     = 19;
    localparam int Q20_SHIFT = 20;
    localparam logic [TAN_W-1:0] TAN_PI8_Q20 = 19'd434334;
    localparam int PROD_W    = TAN_W + PIX_W;
    localparam int SHIFT_W   = PIX_W + Q20_SHIFT;

    // Field index of each ring position, walking left, down-left, down, down-right,
    // right, up-right, up, up-left.
    localparam logic [3:0] RING_POS [RING_LEN] = '{
        4'(IDX_LEFT), 4'(IDX_DOWN_LEFT), 4'(IDX_DOWN), 4'(IDX_DOWN_RIGHT),
        4'(IDX_RIGHT), 4'(IDX_UP_RIGHT), 4'(IDX_UP), 4'(IDX_UP_LEFT)
    };

    // First-quadrant sub-bins.
    localparam logic [1:0] SUB_NEAR_X    = 2'd0;
    localparam logic [1:0] SUB_DIAGONAL  = 2'd1;
    localparam logic [1:0] SUB_NEAR_Y    = 2'd2;

    typedef logic [PIX_W-1:0]             pixel_t;
    typedef pixel_t [NUM_PIX-1:0]         patch_t;
    typedef logic [BIN_W-1:0]             bin_t;

    // Gradient magnitudes and signs handed from the gradient stage.
    typedef struct packed {
        pixel_t ax;
        pixel_t ay;
        logic   dx_neg;
        logic   dy_neg;
        logic   flat;
    } grad_t;

endpackage

/* sv/pon_grad_stage.sv */
// First pipeline stage: gradient differences, their magnitudes and signs.
`timescale 1ns / 1ps

module pon_grad_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pon_pkg::patch_t in_patch,
    output logic            out_valid,
    input  logic            out_ready,
    output pon_pkg::patch_t out_patch,
    output pon_pkg::grad_t  out_grad
);
    import pon_pkg::*;

    logic                    valid_reg;
    patch_t                  patch_reg;
    grad_t                   grad_reg;
    grad_t                   grad_next;
    logic signed [PIX_W:0]   dx;
    logic signed [PIX_W:0]   dy;
    logic signed [PIX_W:0]   dx_abs;
    logic signed [PIX_W:0]   dy_abs;

    // Differences right - left and down - up, then their absolute values.
    always_comb begin
        dx = $signed({1'b0, in_patch[IDX_RIGHT]}) - $signed({1'b0, in_patch[IDX_LEFT]});
        dy = $signed({1'b0, in_patch[IDX_DOWN]}) - $signed({1'b0, in_patch[IDX_UP]});
        dx_abs = dx[PIX_W] ? -dx : dx;
        dy_abs = dy[PIX_W] ? -dy : dy;
        grad_next.ax     = dx_abs[PIX_W-1:0];
        grad_next.ay     = dy_abs[PIX_W-1:0];
        grad_next.dx_neg = dx[PIX_W];
        grad_next.dy_neg = dy[PIX_W];
        grad_next.flat   = (dx == '0) && (dy == '0);
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register; it advances whenever it is empty or its contents move on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            patch_reg <= in_patch;
            grad_reg  <= grad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_patch = patch_reg;
    assign out_grad  = grad_reg;

endmodule

/* sv/pon_octant_stage.sv */
// Second pipeline stage: octant test against tan(pi/8) and mapping to a full bin.
`timescale 1ns / 1ps

module pon_octant_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pon_pkg::patch_t in_patch,
    input  pon_pkg::grad_t  in_grad,
    output logic            out_valid,
    input  logic            out_ready,
    output pon_pkg::patch_t out_patch,
    output pon_pkg::bin_t   out_bin
);
    import pon_pkg::*;

    logic                 valid_reg;
    patch_t               patch_reg;
    bin_t                 bin_reg;
    bin_t                 bin_next;
    logic [PROD_W-1:0]    prod_x;
    logic [PROD_W-1:0]    prod_y;
    logic [SHIFT_W-1:0]   ay_shift;
    logic [SHIFT_W-1:0]   ax_shift;
    logic [1:0]           sub_bin;

    // Compare each magnitude, scaled by 2^20, with the other one times tan(pi/8).
    always_comb begin
        prod_x   = {{PIX_W{1'b0}}, TAN_PI8_Q20} * {{TAN_W{1'b0}}, in_grad.ax};
        prod_y   = {{PIX_W{1'b0}}, TAN_PI8_Q20} * {{TAN_W{1'b0}}, in_grad.ay};
        ay_shift = {in_grad.ay, {Q20_SHIFT{1'b0}}};
        ax_shift = {in_grad.ax, {Q20_SHIFT{1'b0}}};
        priority if (ay_shift < {1'b0, prod_x}) begin
            sub_bin = SUB_NEAR_X;
        end else if (ax_shift < {1'b0, prod_y}) begin
            sub_bin = SUB_NEAR_Y;
        end else begin
            sub_bin = SUB_DIAGONAL;
        end
    end

    // Fold the sub-bin out to the quadrant given by the gradient signs.
    always_comb begin
        priority if (in_grad.flat) begin
            bin_next = '0;
        end else if (!in_grad.dy_neg && !in_grad.dx_neg) begin
            bin_next = {1'b0, sub_bin};
        end else if (!in_grad.dy_neg) begin
            bin_next = 3'd4 - {1'b0, sub_bin};
        end else if (in_grad.dx_neg) begin
            bin_next = 3'd4 + {1'b0, sub_bin};
        end else begin
            bin_next = 3'd0 - {1'b0, sub_bin};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            patch_reg <= in_patch;
            bin_reg   <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_patch = patch_reg;
    assign out_bin   = bin_reg;

endmodule

/* sv/pon_rotate_stage.sv */
// Third pipeline stage: ring rotation by the bin, held in the output register.
`timescale 1ns / 1ps

module pon_rotate_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rotate_en,
    input  logic            in_valid,
    output logic            in_ready,
    input  pon_pkg::patch_t in_patch,
    input  pon_pkg::bin_t   in_bin,
    output logic            out_valid,
    input  logic            out_ready,
    output pon_pkg::patch_t out_patch
);
    import pon_pkg::*;

    logic                   valid_reg;
    patch_t                 patch_reg;
    patch_t                 patch_next;
    pixel_t [RING_LEN-1:0]  ring;
    bin_t                   src;

    // Ring position k takes the ring element at (k + bin) mod 8; the centre passes.
    always_comb begin
        for (int i = 0; i < RING_LEN; i++) begin
            ring[i] = in_patch[RING_POS[i]];
        end
        patch_next = in_patch;
        src = '0;
        if (rotate_en) begin
            for (int i = 0; i < RING_LEN; i++) begin
                src = BIN_W'(i) + in_bin;
                patch_next[RING_POS[i]] = ring[src];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            patch_reg <= patch_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_patch = patch_reg;

endmodule

/* sv/patch_orientation_normalize_unit.sv */
// Top level of the patch orientation normalize block.
//
// Each input transaction on the s_ channel carries one 3x3 patch of bytes in
// s_tdata. The block finds the gradient direction of the patch, quantizes it to
// one of eight octant bins and rotates the eight ring pixels by that bin; the
// centre pixel passes unchanged. The result leaves as one transaction on the m_
// channel, with the same field layout in m_tdata.
// The cfg_ channel writes the one-bit enable; with it clear, patches pass
// through unchanged. Write it only while no patch is in flight.
// The result passes through three registered stages: the gradient stage, the
// octant stage (two 19x8 multiplies and compares) and the rotation stage with
// the output register.
// Throughput is one patch per cycle while m_tready is high; each stage holds one patch.
// When the receiver stalls, each stage holds its patch and s_tready falls once
// all three stages are full; nothing is lost or repeated.
// Reset empties the pipeline and clears the enable.
`timescale 1ns / 1ps

module patch_orientation_normalize_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Fields from bit 0 up: in_up_left, in_up, in_up_right, in_left, in_centre,
    // in_right, in_down_left, in_down, in_down_right (8 bits each).
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0 up: out_up_left, out_up, out_up_right, out_left,
    // out_centre, out_right, out_down_left, out_down, out_down_right (8 bits each).
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import pon_pkg::*;

    logic   orient_enable_reg;
    logic   grad_valid;
    logic   grad_ready;
    patch_t grad_patch;
    grad_t  grad_data;
    logic   oct_valid;
    logic   oct_ready;
    patch_t oct_patch;
    bin_t   oct_bin;
    patch_t out_patch;

    // Enable register, written by a cfg transaction.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_enable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            orient_enable_reg <= cfg_data;
        end
    end

    pon_grad_stage u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_patch  (patch_t'(s_tdata)),
        .out_valid (grad_valid),
        .out_ready (grad_ready),
        .out_patch (grad_patch),
        .out_grad  (grad_data)
    );

    pon_octant_stage u_octant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (grad_valid),
        .in_ready  (grad_ready),
        .in_patch  (grad_patch),
        .in_grad   (grad_data),
        .out_valid (oct_valid),
        .out_ready (oct_ready),
        .out_patch (oct_patch),
        .out_bin   (oct_bin)
    );

    pon_rotate_stage u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rotate_en (orient_enable_reg),
        .in_valid  (oct_valid),
        .in_ready  (oct_ready),
        .in_patch  (oct_patch),
        .in_bin    (oct_bin),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_patch (out_patch)
    );

    assign m_tdata = 72'(out_patch);

endmodule

/* sim/patch_orientation_normalize_unit_test.sv */
// Self-checking testbench for the patch orientation normalize unit.
`timescale 1ns / 1ps

module patch_orientation_normalize_unit_test;

    import pon_pkg::*;

    // tan(22.5 deg) as an unsigned fraction with 20 fractional bits.
    localparam longint unsigned TAN_22P5_Q20 = 434334;
    localparam int              FRAC_BITS    = 20;
    localparam int              MAX_PRINTED  = 40;

    // Directed gradients, packed as {up, down, left, right}.
    localparam int NUM_GRADIENT_CASES = 18;
    localparam logic [31:0] GRADIENT_CASES [NUM_GRADIENT_CASES] = '{
        {8'd100, 8'd100, 8'd0,   8'd255},   // pointing right
        {8'd0,   8'd255, 8'd0,   8'd255},   // down-right diagonal
        {8'd0,   8'd255, 8'd50,  8'd50},    // straight down
        {8'd10,  8'd90,  8'd200, 8'd120},   // down-left diagonal
        {8'd128, 8'd128, 8'd255, 8'd0},     // angle of pi
        {8'd255, 8'd0,   8'd255, 8'd0},     // up-left diagonal
        {8'd255, 8'd0,   8'd7,   8'd7},     // straight up
        {8'd60,  8'd20,  8'd30,  8'd70},    // up-right diagonal
        {8'd0,   8'd105, 8'd0,   8'd255},   // just below the first boundary
        {8'd0,   8'd106, 8'd0,   8'd255},   // just above the first boundary
        {8'd0,   8'd255, 8'd0,   8'd105},   // just past the second boundary
        {8'd0,   8'd255, 8'd0,   8'd106},   // just short of the second boundary
        {8'd105, 8'd0,   8'd255, 8'd0},     // near pi from below
        {8'd255, 8'd0,   8'd106, 8'd0},     // up-left side of the boundary
        {8'd9,   8'd9,   8'd40,  8'd41},    // smallest step right
        {8'd33,  8'd32,  8'd90,  8'd90},    // smallest step up
        {8'd0,   8'd1,   8'd1,   8'd0},     // smallest down-left diagonal
        {8'd0,   8'd1,   8'd0,   8'd2}      // small diagonal
    };

    // Predicts each rotated patch and checks the results in order.
    class ring_rotation_checker;
        logic   rotate_en;
        patch_t expected_patches [$];
        int     mismatches;
        int     patches_seen;
        int     rotated_seen;
        int     results_seen;
        int     bin_hits [RING_LEN];

        function new();
            rotate_en    = 1'b0;
            mismatches   = 0;
            patches_seen = 0;
            rotated_seen = 0;
            results_seen = 0;
            foreach (bin_hits[i]) bin_hits[i] = 0;
        endfunction

        // Quantizes the gradient angle to the nearest multiple of pi/4.
        function bin_t gradient_bin(pixel_t up, pixel_t down, pixel_t left, pixel_t right);
            int              dx;
            int              dy;
            longint unsigned ax;
            longint unsigned ay;
            logic [1:0]      sub;
            int              bin_val;
            dx = int'(right) - int'(left);
            dy = int'(down) - int'(up);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax == 0 && ay == 0)
                return '0;
            if ((ay << FRAC_BITS) < TAN_22P5_Q20 * ax)
                sub = SUB_NEAR_X;
            else if ((ax << FRAC_BITS) < TAN_22P5_Q20 * ay)
                sub = SUB_NEAR_Y;
            else
                sub = SUB_DIAGONAL;
            // Unfold the first-quadrant sub-bin by the signs of the gradient.
            if (dy >= 0)
                bin_val = (dx >= 0) ? sub : 4 - sub;
            else
                bin_val = (dx < 0) ? 4 + sub : 8 - sub;
            return bin_t'(bin_val);
        endfunction

        function patch_t predict(patch_t px);
            patch_t rotated;
            bin_t   b;
            rotated = px;
            if (!rotate_en)
                return px;
            b = gradient_bin(px[IDX_UP], px[IDX_DOWN], px[IDX_LEFT], px[IDX_RIGHT]);
            bin_hits[b]++;
            for (int k = 0; k < RING_LEN; k++)
                rotated[RING_POS[k]] = px[RING_POS[(k + b) % RING_LEN]];
            return rotated;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void note_patch(patch_t px);
            patches_seen++;
            if (rotate_en)
                rotated_seen++;
            expected_patches = {expected_patches, predict(px)};
        endfunction

        task check_patch(patch_t got);
            patch_t want;
            results_seen++;
            if (expected_patches.size() == 0) begin
                report($sformatf("result %h arrived with no patch outstanding", got));
                return;
            end
            want = expected_patches.pop_front();
            for (int i = 0; i < NUM_PIX; i++) begin
                if (got[i] !== want[i])
                    report($sformatf("result %0d pixel %0d: got %h, expected %h",
                                     results_seen, i, got[i], want[i]));
            end
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [71:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    ring_rotation_checker sb = new();

    // Final stretch of the run: no idling on either side.
    bit          steady      = 1'b0;
    int unsigned gap_pct     = 0;
    int unsigned out_burst   = 0;
    bit          out_stalled = 1'b0;

    patch_orientation_normalize_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Receiver: alternating bursts of stall and readiness, always ready once steady.
    always @(posedge aclk) begin
        if (steady) begin
            m_tready <= 1'b1;
        end else begin
            if (out_burst == 0) begin
                out_stalled = !out_stalled;
                if (out_stalled)
                    out_burst = $urandom_range(1, 18);
                else if ($urandom_range(0, 7) == 0)
                    out_burst = $urandom_range(100, 200);
                else
                    out_burst = $urandom_range(1, 40);
            end
            out_burst = out_burst - 1;
            m_tready <= !out_stalled;
        end
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_patch(m_tdata);
    end

    // Sends one patch and waits for its transaction, then maybe idles.
    task automatic push_patch(input patch_t px);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_patch(px);
        if (!steady && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Writes the enable once the pipeline has emptied.
    task automatic set_enable(input logic en);
        s_tvalid <= 1'b0;
        while (sb.expected_patches.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.rotate_en = en;
    endtask

    // Random patch, often shaped toward flat axes, tiny gradients or extremes.
    function automatic patch_t random_patch();
        patch_t px;
        for (int i = 0; i < NUM_PIX; i++)
            px[i] = pixel_t'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: px[IDX_RIGHT] = px[IDX_LEFT];
            1: px[IDX_DOWN]  = px[IDX_UP];
            2: begin
                px[IDX_RIGHT] = px[IDX_LEFT];
                px[IDX_DOWN]  = px[IDX_UP];
            end
            3, 4: begin
                px[IDX_DOWN]  = px[IDX_UP] + pixel_t'($urandom_range(0, 6)) - 8'd3;
                px[IDX_RIGHT] = px[IDX_LEFT] + pixel_t'($urandom_range(0, 6)) - 8'd3;
            end
            5: begin
                for (int i = 0; i < NUM_PIX; i++)
                    px[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic stream_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 25;
                    default: gap_pct = 50;
                endcase
            end
            push_patch(random_patch());
        end
    endtask

    // Run timeout.
    initial begin
        #1_000_000;
        $display("patch_orientation_normalize_unit regression: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        patch_t px;
        int     wait_cycles;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Enable left at its reset value: patches pass through.
        stream_random(6);

        // Directed patches with rotation on.
        set_enable(1'b1);
        gap_pct = 20;
        push_patch('0);
        push_patch('1);
        for (int c = 0; c < NUM_GRADIENT_CASES; c++) begin
            px = random_patch();
            {px[IDX_UP], px[IDX_DOWN], px[IDX_LEFT], px[IDX_RIGHT]} = GRADIENT_CASES[c];
            push_patch(px);
        end

        set_enable(1'b0);
        stream_random(40);

        set_enable(1'b1);
        stream_random(300);

        // Closing stretch at full rate.
        steady = 1'b1;
        stream_random(60);
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.expected_patches.size() != 0 && wait_cycles < 2000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (sb.expected_patches.size() != 0)
            sb.report($sformatf("%0d patches never produced a result",
                                sb.expected_patches.size()));

        $display("Covered %0d patches, %0d rotated and %0d passed through, enable toggled.",
                 sb.patches_seen, sb.rotated_seen, sb.patches_seen - sb.rotated_seen);
        $display("Octant bins hit while rotating: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.bin_hits[0], sb.bin_hits[1], sb.bin_hits[2], sb.bin_hits[3],
                 sb.bin_hits[4], sb.bin_hits[5], sb.bin_hits[6], sb.bin_hits[7]);
        if (sb.mismatches == 0) begin
            $display("patch_orientation_normalize_unit regression: pass");
        end else begin
            $display("patch_orientation_normalize_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
sv/pon_pkg.sv
sv/pon_grad_stage.sv
sv/pon_octant_stage.sv
sv/pon_rotate_stage.sv
sv/patch_orientation_normalize_unit.sv
sim/patch_orientation_normalize_unit_test.sv
